FILE: rtl/kit_pkg.sv
// ----------------------------------------------------------------------------
// kit_pkg
// Shared types and constants for the keyed inventory table.
// ----------------------------------------------------------------------------
package kit_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int MAX_RESULTS = 64;
    localparam int WORD_W      = 32;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_BUY    = 2'd1,
        ACT_SELL   = 2'd2,
        ACT_SHOW   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4,
        ST_RECORD    = 3'd5,
        ST_EMPTY     = 3'd6
    } status_t;

    // one stored record, key in the low bits
    typedef struct packed {
        logic [WORD_W-1:0] price;
        logic [WORD_W-1:0] stock;
        logic [WORD_W-1:0] key;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        action_t           action;
        logic [WORD_W-1:0] price;
        logic [WORD_W-1:0] amount;
        logic [WORD_W-1:0] key;
    } cmd_t;

    typedef struct packed {
        status_t status;
        rec_t    rec;
        logic    last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SEARCH_WAIT,
        S_PROBE_WAIT,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SHOW_RD,
        S_SHOW_WAIT,
        S_EMIT
    } fsm_t;

endpackage

FILE: rtl/kit_mem.sv
// ----------------------------------------------------------------------------
// kit_mem
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kit_mem #(
    parameter int ENTRIES = kit_pkg::ENTRIES_DEF,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  kit_pkg::rec_t wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output kit_pkg::rec_t rd_data
);

    kit_pkg::rec_t mem [ENTRIES];
    kit_pkg::rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/kit_ctrl.sv
// ----------------------------------------------------------------------------
// kit_ctrl
// Command sequencer: binary search, insert shift, update and listing.
// ----------------------------------------------------------------------------
module kit_ctrl #(
    parameter int ENTRIES = kit_pkg::ENTRIES_DEF,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int CW      = $clog2(ENTRIES + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  kit_pkg::cmd_t      in_cmd,
    input  logic               out_space,
    output logic               out_push,
    output kit_pkg::out_item_t out_item,
    output logic               mem_wr_en,
    output logic [AW-1:0]      mem_wr_addr,
    output kit_pkg::rec_t      mem_wr_data,
    output logic               mem_rd_en,
    output logic [AW-1:0]      mem_rd_addr,
    input  kit_pkg::rec_t      mem_rd_data
);

    localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

    kit_pkg::fsm_t      state_reg, state_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      mid_reg, mid_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      show_n_reg, show_n_next;
    logic               found_reg, found_next;
    kit_pkg::cmd_t      cmd_reg, cmd_next;
    kit_pkg::rec_t      cur_reg, cur_next;
    kit_pkg::out_item_t out_reg, out_next;

    logic [CW-1:0]           mid_calc;
    logic [kit_pkg::WORD_W:0] sum_calc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kit_pkg::S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        idx_reg    <= idx_next;
        show_n_reg <= show_n_next;
        found_reg  <= found_next;
        cmd_reg    <= cmd_next;
        cur_reg    <= cur_next;
        out_reg    <= out_next;
    end

    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign sum_calc = {1'b0, cur_reg.stock} + {1'b0, cmd_reg.amount};

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        idx_next    = idx_reg;
        show_n_next = show_n_reg;
        found_next  = found_reg;
        cmd_next    = cmd_reg;
        cur_next    = cur_reg;
        out_next    = out_reg;

        in_ready    = 1'b0;
        out_push    = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;

        case (state_reg)
            kit_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next = in_cmd;
                    lo_next  = '0;
                    hi_next  = fill_reg;
                    idx_next = '0;
                    if (in_cmd.action == kit_pkg::ACT_SHOW)
                    begin
                        if (fill_reg == '0)
                        begin
                            out_next.status = kit_pkg::ST_EMPTY;
                            out_next.rec    = '0;
                            out_next.last   = 1'b1;
                            state_next      = kit_pkg::S_EMIT;
                        end
                        else
                        begin
                            if (32'(fill_reg) > 32'(kit_pkg::MAX_RESULTS))
                            begin
                                show_n_next = CW'(kit_pkg::MAX_RESULTS);
                            end
                            else
                            begin
                                show_n_next = fill_reg;
                            end
                            state_next = kit_pkg::S_SHOW_RD;
                        end
                    end
                    else
                    begin
                        state_next = kit_pkg::S_SEARCH;
                    end
                end
            end

            kit_pkg::S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next    = mid_calc;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = mid_calc[AW-1:0];
                    state_next  = kit_pkg::S_SEARCH_WAIT;
                end
                else if (lo_reg < fill_reg)
                begin
                    // lower bound found; fetch it to test for a match
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = lo_reg[AW-1:0];
                    state_next  = kit_pkg::S_PROBE_WAIT;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = kit_pkg::S_DECIDE;
                end
            end

            kit_pkg::S_SEARCH_WAIT:
            begin
                if (mem_rd_data.key < cmd_reg.key)
                begin
                    lo_next = mid_reg + CW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = kit_pkg::S_SEARCH;
            end

            kit_pkg::S_PROBE_WAIT:
            begin
                found_next = (mem_rd_data.key == cmd_reg.key);
                cur_next   = mem_rd_data;
                state_next = kit_pkg::S_DECIDE;
            end

            kit_pkg::S_DECIDE:
            begin
                out_next.last     = 1'b1;
                out_next.rec.key  = cmd_reg.key;
                state_next        = kit_pkg::S_EMIT;
                case (cmd_reg.action)
                    kit_pkg::ACT_INSERT:
                    begin
                        if (found_reg)
                        begin
                            out_next.status = kit_pkg::ST_DUPLICATE;
                            out_next.rec    = cur_reg;
                        end
                        else if (fill_reg == FULL_COUNT)
                        begin
                            out_next.status    = kit_pkg::ST_FULL;
                            out_next.rec.stock = '0;
                            out_next.rec.price = '0;
                        end
                        else
                        begin
                            idx_next   = fill_reg;
                            state_next = kit_pkg::S_SHIFT_RD;
                        end
                    end

                    kit_pkg::ACT_BUY, kit_pkg::ACT_SELL:
                    begin
                        if (!found_reg)
                        begin
                            out_next.status    = kit_pkg::ST_NOT_FOUND;
                            out_next.rec.stock = '0;
                            out_next.rec.price = '0;
                        end
                        else if (cmd_reg.action == kit_pkg::ACT_BUY &&
                                 cur_reg.stock < cmd_reg.amount)
                        begin
                            out_next.status = kit_pkg::ST_SHORT;
                            out_next.rec    = cur_reg;
                        end
                        else
                        begin
                            out_next.status = kit_pkg::ST_OK;
                            out_next.rec    = cur_reg;
                            if (cmd_reg.action == kit_pkg::ACT_BUY)
                            begin
                                out_next.rec.stock = cur_reg.stock - cmd_reg.amount;
                            end
                            else if (sum_calc[kit_pkg::WORD_W])
                            begin
                                out_next.rec.stock = '1;
                            end
                            else
                            begin
                                out_next.rec.stock = sum_calc[kit_pkg::WORD_W-1:0];
                            end
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = lo_reg[AW-1:0];
                            mem_wr_data = out_next.rec;
                        end
                    end

                    default:
                    begin
                        state_next = kit_pkg::S_IDLE;
                    end
                endcase
            end

            kit_pkg::S_SHIFT_RD:
            begin
                if (idx_reg > lo_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg[AW-1:0] - AW'(1);
                    state_next  = kit_pkg::S_SHIFT_WR;
                end
                else
                begin
                    out_next.status    = kit_pkg::ST_OK;
                    out_next.rec.key   = cmd_reg.key;
                    out_next.rec.stock = cmd_reg.amount;
                    out_next.rec.price = cmd_reg.price;
                    out_next.last      = 1'b1;
                    mem_wr_en          = 1'b1;
                    mem_wr_addr        = lo_reg[AW-1:0];
                    mem_wr_data        = out_next.rec;
                    fill_next          = fill_reg + CW'(1);
                    state_next         = kit_pkg::S_EMIT;
                end
            end

            kit_pkg::S_SHIFT_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_reg[AW-1:0];
                mem_wr_data = mem_rd_data;
                idx_next    = idx_reg - CW'(1);
                state_next  = kit_pkg::S_SHIFT_RD;
            end

            kit_pkg::S_SHOW_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_reg[AW-1:0];
                state_next  = kit_pkg::S_SHOW_WAIT;
            end

            kit_pkg::S_SHOW_WAIT:
            begin
                out_next.status = kit_pkg::ST_RECORD;
                out_next.rec    = mem_rd_data;
                out_next.last   = ((idx_reg + CW'(1)) == show_n_reg);
                state_next      = kit_pkg::S_EMIT;
            end

            kit_pkg::S_EMIT:
            begin
                if (out_space)
                begin
                    out_push = 1'b1;
                    if (out_reg.last)
                    begin
                        state_next = kit_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = kit_pkg::S_SHOW_RD;
                    end
                end
            end

            default:
            begin
                state_next = kit_pkg::S_IDLE;
            end
        endcase
    end

    assign out_item = out_reg;

endmodule

FILE: rtl/keyed_inventory_table.sv
// ----------------------------------------------------------------------------
// keyed_inventory_table
// Sorted keyed table of inventory records with insert, buy, sell and show.
// ----------------------------------------------------------------------------
// One command enters on the s_ channel (action on s_tuser, key, amount and
// price on s_tdata); results leave on the m_ channel with the status on
// m_tuser and m_tlast on the final result of a command. s_tready is high
// only while no command is in progress: one command at a time.
// Buy and sell take a binary search (each probe a read of the middle slot
// and a key compare), then fetch the bound slot, decide and hand the result
// to the output register. Insert also moves every record at or above the new
// slot up one slot, each move a read followed by a write on the single record
// memory. Show lists the records one at a time, at most 64 records. Results
// sit in an output register, so the sequencer keeps working while the
// receiver holds off; if m_tready stays low the sequencer waits with its
// next result. Reset empties the table (the record count goes to zero, the
// memory is not cleared) and drops any pending result.
// ----------------------------------------------------------------------------
module keyed_inventory_table #(
    parameter int ENTRIES = kit_pkg::ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // key[31:0], amount[63:32], unit_price[95:64]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // rec_key[31:0], rec_stock[63:32], rec_price[95:64]
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    kit_pkg::cmd_t      cmd;
    kit_pkg::out_item_t item;
    kit_pkg::out_item_t m_item_reg;
    logic               m_valid_reg;
    logic               out_space;
    logic               out_push;

    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    kit_pkg::rec_t      mem_wr_data;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    kit_pkg::rec_t      mem_rd_data;

    assign cmd.action = kit_pkg::action_t'(s_tuser);
    assign cmd.key    = s_tdata[31:0];
    assign cmd.amount = s_tdata[63:32];
    assign cmd.price  = s_tdata[95:64];

    kit_ctrl #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .CW      (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (cmd),
        .out_space   (out_space),
        .out_push    (out_push),
        .out_item    (item),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    kit_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register frees up in the same cycle its transaction completes
    assign out_space = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_push)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            m_item_reg <= item;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_item_reg.rec.price, m_item_reg.rec.stock, m_item_reg.rec.key};
    assign m_tuser  = m_item_reg.status;
    assign m_tlast  = m_item_reg.last;

endmodule
